[src/normalized_rotate_add_vector_assert.svh]
// Assertion macros for the normalized rotate-add vector block.
`ifndef NORMALIZED_ROTATE_ADD_VECTOR_ASSERT_SVH
`define NORMALIZED_ROTATE_ADD_VECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define NRAV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NRAV_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define NRAV_ASSERT(lbl, prop, msg)
`define NRAV_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/nrav_pkg.sv]
package nrav_pkg;

    localparam int SQ_STEPS     = 32;
    localparam int LDIV_STEPS   = 31;
    localparam int DDIV_STEPS   = 63;
    localparam int DE_UPDATE_DEF = 0;

    localparam logic [31:0] OFF_RST   = 32'h0000_0000;
    localparam logic [31:0] SCALE_RST = 32'h0040_0000;
    localparam logic [47:0] ROT0_RST  = 48'h4000_0000_0000;
    localparam logic [47:0] ROT1_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] ROT2_RST  = 48'h0000_0000_4000;
    localparam logic [63:0] DEP_RST   = 64'h0040_0000_0000_0000;

    localparam logic [30:0] UNIT_Q = 31'h4000_0000;
    localparam logic [40:0] MAG_CLAMP = 41'h100_0000_0000;

    typedef enum logic [2:0] {
        REG_OFF_X     = 3'd0,
        REG_OFF_Y     = 3'd1,
        REG_OFF_Z     = 3'd2,
        REG_ADD_SCALE = 3'd3,
        REG_ROT0      = 3'd4,
        REG_ROT1      = 3'd5,
        REG_ROT2      = 3'd6,
        REG_DE_PARAMS = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][31:0] t;
        logic [31:0]      de;
        logic [30:0]      rad;
    } ctx_t;

    typedef struct packed {
        logic [63:0] x;
        logic [32:0] rem;
        logic [31:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [2:0][31:0] z;
        logic [31:0]      de;
        logic [30:0]      rad;
        logic             degen;
    } res_t;

    function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
        logic [34:0] cur;
        logic [34:0] trial;
        sqrt_st_t    o;
        cur   = {s.rem, s.x[63:62]};
        trial = {1'b0, s.root, 2'b01};
        o.x   = {s.x[61:0], 2'b00};
        if (cur >= trial)
        begin
            o.rem  = 33'(cur - trial);
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = cur[32:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // {remainder, quotient bit}
    function automatic logic [32:0] div_step(logic [31:0] r, logic [31:0] d, logic b);
        logic [32:0] cur;
        cur = {r, b};
        if (cur >= {1'b0, d})
            return {32'(cur - {1'b0, d}), 1'b1};
        else
            return {cur[31:0], 1'b0};
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [31:0] sat32(logic signed [43:0] v);
        if (v > 44'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -44'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

[src/normalized_rotate_add_vector.sv]
// Channel | Dir | Fields
// s_*     | in  | point_x, point_y, point_z, deriv_in, radius_in
// m_*     | out | new_x, new_y, new_z, deriv_out; tuser = degenerate
// cfg_*   | in  | register write, index 0..7
//
// One item per cycle unless m_* stalls. Main path: 32-step square root, then
// 31-step bit-serial dividers; derivative update: 32-step root, 63-step divider.
// rst_n clears valid bits and loads register defaults.
// A stall at m_* freezes every stage; nothing is lost or repeated.
`include "normalized_rotate_add_vector_assert.svh"

module normalized_rotate_add_vector #(
    parameter int DE_UPDATE_ON = nrav_pkg::DE_UPDATE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, deriv_in, radius_in, pad
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_x, new_y, new_z, deriv_out
    output logic [127:0] m_tdata,
    // degenerate
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam int MAIN_DEPTH = 6 + (nrav_pkg::SQ_STEPS + 1) + (nrav_pkg::LDIV_STEPS + 1);
    localparam int DE_DEPTH   = 5 + (nrav_pkg::SQ_STEPS + 1) + nrav_pkg::DDIV_STEPS;
    localparam int DEPTH      = MAIN_DEPTH + ((DE_UPDATE_ON != 0) ? DE_DEPTH : 0);
    localparam int DV_LAST    = 3 + nrav_pkg::SQ_STEPS + nrav_pkg::LDIV_STEPS;

    typedef struct packed {
        nrav_pkg::ctx_t   c;
        logic [2:0][63:0] sq;
    } sq_stage_t;

    typedef struct packed {
        nrav_pkg::ctx_t     c;
        nrav_pkg::sqrt_st_t s;
    } sr_stage_t;

    typedef struct packed {
        nrav_pkg::ctx_t   c;
        logic [31:0]      len;
        logic [2:0][31:0] r;
        logic [2:0][30:0] q;
    } dv_stage_t;

    typedef struct packed {
        nrav_pkg::ctx_t        c;
        logic                  zl;
        logic [2:0][2:0][47:0] p;
    } mm_stage_t;

    typedef struct packed {
        nrav_pkg::ctx_t   c;
        logic             zl;
        logic [2:0][35:0] a;
    } ac_stage_t;

    typedef struct packed {
        nrav_pkg::ctx_t   c;
        logic             zl;
        logic [2:0][25:0] r;
    } rs_stage_t;

    // configuration
    logic [2:0][31:0] off_reg;
    logic [31:0]      scale_reg;
    logic [2:0][47:0] rot_reg;
    logic [63:0]      dep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= {3{nrav_pkg::OFF_RST}};
            scale_reg <= nrav_pkg::SCALE_RST;
            rot_reg   <= {nrav_pkg::ROT2_RST, nrav_pkg::ROT1_RST, nrav_pkg::ROT0_RST};
            dep_reg   <= nrav_pkg::DEP_RST;
        end
        else if (cfg_we)
        begin
            case (nrav_pkg::reg_idx_t'(cfg_addr))
                nrav_pkg::REG_OFF_X:     off_reg[0] <= cfg_wdata[31:0];
                nrav_pkg::REG_OFF_Y:     off_reg[1] <= cfg_wdata[31:0];
                nrav_pkg::REG_OFF_Z:     off_reg[2] <= cfg_wdata[31:0];
                nrav_pkg::REG_ADD_SCALE: scale_reg  <= cfg_wdata[31:0];
                nrav_pkg::REG_ROT0:      rot_reg[0] <= cfg_wdata[47:0];
                nrav_pkg::REG_ROT1:      rot_reg[1] <= cfg_wdata[47:0];
                nrav_pkg::REG_ROT2:      rot_reg[2] <= cfg_wdata[47:0];
                nrav_pkg::REG_DE_PARAMS: dep_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    nrav_pkg::res_t   out_res;

    assign adv      = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = {out_res.de, out_res.z[2], out_res.z[1], out_res.z[0]};
    assign m_tuser  = out_res.degen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
    end

    // offset add
    nrav_pkg::ctx_t st1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                st1_reg.t[j] <= nrav_pkg::sat32(44'($signed(s_tdata[32*j +: 32]))
                                               + 44'($signed(off_reg[j])));
            st1_reg.de  <= s_tdata[127:96];
            st1_reg.rad <= s_tdata[158:128];
        end
    end

    // squares
    sq_stage_t st2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st2_reg.c <= st1_reg;
            for (int j = 0; j < 3; j++)
                st2_reg.sq[j] <= nrav_pkg::mag32(st1_reg.t[j]) * nrav_pkg::mag32(st1_reg.t[j]);
        end
    end

    // length square root
    sr_stage_t sr_reg [nrav_pkg::SQ_STEPS+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sr_reg[0].c      <= st2_reg.c;
            sr_reg[0].s.x    <= st2_reg.sq[0] + st2_reg.sq[1] + st2_reg.sq[2];
            sr_reg[0].s.rem  <= '0;
            sr_reg[0].s.root <= '0;
        end
    end

    for (genvar k = 1; k <= nrav_pkg::SQ_STEPS; k++)
    begin : g_sr
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_reg[k].c <= sr_reg[k-1].c;
                sr_reg[k].s <= nrav_pkg::sqrt_step(sr_reg[k-1].s);
            end
        end
    end

    // normalize divide, three lanes
    dv_stage_t dv_reg [nrav_pkg::LDIV_STEPS+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0].c   <= sr_reg[nrav_pkg::SQ_STEPS].c;
            dv_reg[0].len <= sr_reg[nrav_pkg::SQ_STEPS].s.root;
            for (int j = 0; j < 3; j++)
            begin
                dv_reg[0].r[j] <= {1'b0, nrav_pkg::mag32(sr_reg[nrav_pkg::SQ_STEPS].c.t[j])
                                   [31:1]};
                dv_reg[0].q[j] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= nrav_pkg::LDIV_STEPS; k++)
    begin : g_dv
        logic [2:0][32:0] nx;
        always_comb
        begin
            for (int j = 0; j < 3; j++)
                nx[j] = nrav_pkg::div_step(dv_reg[k-1].r[j], dv_reg[k-1].len,
                                           (k == 1) ? dv_reg[k-1].c.t[j][0] : 1'b0);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k].c   <= dv_reg[k-1].c;
                dv_reg[k].len <= dv_reg[k-1].len;
                for (int j = 0; j < 3; j++)
                begin
                    dv_reg[k].r[j] <= nx[j][32:1];
                    dv_reg[k].q[j] <= {dv_reg[k-1].q[j][29:0], nx[j][0]};
                end
            end
        end
    end

    // rotate: partial products
    logic [2:0][31:0] u;
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            u[j] = dv_reg[nrav_pkg::LDIV_STEPS].c.t[j][31]
                 ? 32'(-{1'b0, dv_reg[nrav_pkg::LDIV_STEPS].q[j]})
                 : {1'b0, dv_reg[nrav_pkg::LDIV_STEPS].q[j]};
    end

    mm_stage_t mm_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mm_reg.c  <= dv_reg[nrav_pkg::LDIV_STEPS].c;
            mm_reg.zl <= (dv_reg[nrav_pkg::LDIV_STEPS].len == 32'd0);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    mm_reg.p[i][j] <= $signed(rot_reg[i][47-16*j -: 16]) * $signed(u[j]);
        end
    end

    // row sums, Q4.44 to Q4.22
    logic [2:0][47:0] acc;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            acc[i] = mm_reg.p[i][0] + mm_reg.p[i][1] + mm_reg.p[i][2];
    end

    rs_stage_t rs_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg.c  <= mm_reg.c;
            rs_reg.zl <= mm_reg.zl;
            for (int i = 0; i < 3; i++)
                rs_reg.r[i] <= acc[i][47:22];
        end
    end

    // gain
    logic signed [2:0][57:0] prod;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod[i] = $signed(rs_reg.r[i]) * $signed(scale_reg);
    end

    ac_stage_t ac_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ac_reg.c  <= rs_reg.c;
            ac_reg.zl <= rs_reg.zl;
            for (int i = 0; i < 3; i++)
                ac_reg.a[i] <= prod[i][57:22];
        end
    end

    // add back, remove offset
    nrav_pkg::res_t fin_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                fin_reg.z[i] <= nrav_pkg::sat32(44'($signed(ac_reg.c.t[i]))
                                + (ac_reg.zl ? 44'sd0 : 44'($signed(ac_reg.a[i])))
                                - 44'($signed(off_reg[i])));
            fin_reg.de    <= ac_reg.c.de;
            fin_reg.rad   <= ac_reg.c.rad;
            fin_reg.degen <= ac_reg.zl;
        end
    end

    if (DE_UPDATE_ON != 0)
    begin : g_de
        typedef struct packed {
            nrav_pkg::res_t   v;
            logic [2:0][63:0] sq;
        } dsq_t;

        typedef struct packed {
            nrav_pkg::res_t     v;
            nrav_pkg::sqrt_st_t s;
        } dsr_t;

        typedef struct packed {
            nrav_pkg::res_t v;
            logic [63:0]    p;
            logic [31:0]    r;
            logic [62:0]    q;
        } ddv_t;

        typedef struct packed {
            nrav_pkg::res_t v;
            logic [63:0]    ph;
            logic [62:0]    pl;
            logic           neg;
        } dm_t;

        typedef struct packed {
            nrav_pkg::res_t v;
            logic [40:0]    m;
            logic           neg;
        } dc_t;

        dsq_t           dsq_reg;
        dsr_t           dsr_reg [nrav_pkg::SQ_STEPS+1];
        ddv_t           ddv_reg [nrav_pkg::DDIV_STEPS+1];
        dm_t            dm_reg;
        dc_t            dc_reg;
        nrav_pkg::res_t dfin_reg;
        logic [31:0]    sa;
        logic [63:0]    tot;
        logic           big;
        logic signed [43:0] val;

        assign sa = nrav_pkg::mag32(dep_reg[63:32]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dsq_reg.v <= fin_reg;
                for (int j = 0; j < 3; j++)
                    dsq_reg.sq[j] <= nrav_pkg::mag32(fin_reg.z[j])
                                   * nrav_pkg::mag32(fin_reg.z[j]);
                dsr_reg[0].v      <= dsq_reg.v;
                dsr_reg[0].s.x    <= dsq_reg.sq[0] + dsq_reg.sq[1] + dsq_reg.sq[2];
                dsr_reg[0].s.rem  <= '0;
                dsr_reg[0].s.root <= '0;
            end
        end

        for (genvar k = 1; k <= nrav_pkg::SQ_STEPS; k++)
        begin : g_dsr
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dsr_reg[k].v <= dsr_reg[k-1].v;
                    dsr_reg[k].s <= nrav_pkg::sqrt_step(dsr_reg[k-1].s);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ddv_reg[0].v <= dsr_reg[nrav_pkg::SQ_STEPS].v;
                ddv_reg[0].p <= nrav_pkg::mag32(dsr_reg[nrav_pkg::SQ_STEPS].v.de)
                              * dsr_reg[nrav_pkg::SQ_STEPS].s.root;
                ddv_reg[0].r <= '0;
                ddv_reg[0].q <= '0;
            end
        end

        for (genvar k = 1; k <= nrav_pkg::DDIV_STEPS; k++)
        begin : g_ddv
            logic [32:0] nx;
            assign nx = nrav_pkg::div_step(ddv_reg[k-1].r, {1'b0, ddv_reg[k-1].v.rad},
                                           ddv_reg[k-1].p[63-k]);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ddv_reg[k].v <= ddv_reg[k-1].v;
                    ddv_reg[k].p <= ddv_reg[k-1].p;
                    ddv_reg[k].r <= nx[32:1];
                    ddv_reg[k].q <= {ddv_reg[k-1].q[61:0], nx[0]};
                end
            end
        end

        assign tot = {dm_reg.ph[31:0], 31'd0} + {1'b0, dm_reg.pl};
        assign big = (dm_reg.ph[63:32] != 32'd0)
                  || (tot[63:22] > {1'b0, nrav_pkg::MAG_CLAMP});
        assign val = dc_reg.neg ? -44'($signed({1'b0, dc_reg.m}))
                                : 44'($signed({1'b0, dc_reg.m}));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dm_reg.v   <= ddv_reg[nrav_pkg::DDIV_STEPS].v;
                dm_reg.ph  <= ddv_reg[nrav_pkg::DDIV_STEPS].q[62:31] * sa;
                dm_reg.pl  <= ddv_reg[nrav_pkg::DDIV_STEPS].q[30:0] * sa;
                dm_reg.neg <= ddv_reg[nrav_pkg::DDIV_STEPS].v.de[31] ^ dep_reg[63];

                dc_reg.v   <= dm_reg.v;
                dc_reg.m   <= big ? nrav_pkg::MAG_CLAMP : tot[62:22];
                dc_reg.neg <= dm_reg.neg;

                dfin_reg.z   <= dc_reg.v.z;
                dfin_reg.rad <= dc_reg.v.rad;
                if (dc_reg.v.rad == 31'd0)
                begin
                    dfin_reg.de    <= dc_reg.v.de;
                    dfin_reg.degen <= 1'b1;
                end
                else
                begin
                    dfin_reg.de    <= nrav_pkg::sat32(val + 44'($signed(dep_reg[31:0])));
                    dfin_reg.degen <= dc_reg.v.degen;
                end
            end
        end

        assign out_res = dfin_reg;
    end
    else
    begin : g_no_de
        assign out_res = fin_reg;
    end

    `NRAV_ASSERT_NEXT(a_take, s_tvalid && s_tready, vld_reg[0], "accepted item not in first stage")
    `NRAV_ASSERT_NEXT(a_hold, !adv, $stable(vld_reg), "valid bits moved during stall")
    `NRAV_ASSERT(a_unit, vld_reg[DV_LAST] && (dv_reg[nrav_pkg::LDIV_STEPS].len != 32'd0) |-> (dv_reg[nrav_pkg::LDIV_STEPS].q[0] <= nrav_pkg::UNIT_Q) && (dv_reg[nrav_pkg::LDIV_STEPS].q[1] <= nrav_pkg::UNIT_Q) && (dv_reg[nrav_pkg::LDIV_STEPS].q[2] <= nrav_pkg::UNIT_Q), "unit vector component above one")

endmodule
